/* design/ovp_pkg.sv */
package ovp_pkg;

    localparam int COORD_W    = 16;
    localparam int DATA_W     = 32;
    localparam int TRIG_W     = 18;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // register stages inside each rotation unit and inside the screen unit
    localparam int ROT_STAGES = 2;
    localparam int SCR_STAGES = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_YAW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_YAW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_PITCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_PAIR  = 3'd7;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [TRIG_W-1:0] trig_t;

    localparam trig_t RESET_COS  = 18'sd65536;
    localparam trig_t RESET_SIN  = 18'sd0;
    localparam word_t RESET_NEAR = 32'sh8000_0000;

    typedef struct packed {
        trig_t model_cos;
        trig_t model_sin;
        trig_t yaw_cos;
        trig_t yaw_sin;
        trig_t pitch_cos;
        trig_t pitch_sin;
        word_t offset_x;
        word_t offset_y;
        word_t offset_z;
        word_t zoom;
        word_t mid_depth;
        word_t near_depth;
    } cfg_t;

endpackage

/* design/ovp_cfg.sv */
module ovp_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ovp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ovp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ovp_pkg::cfg_t                      cfg
);
    import ovp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.model_cos  <= RESET_COS;
            cfg_reg.model_sin  <= RESET_SIN;
            cfg_reg.yaw_cos    <= RESET_COS;
            cfg_reg.yaw_sin    <= RESET_SIN;
            cfg_reg.pitch_cos  <= RESET_COS;
            cfg_reg.pitch_sin  <= RESET_SIN;
            cfg_reg.offset_x   <= '0;
            cfg_reg.offset_y   <= '0;
            cfg_reg.offset_z   <= '0;
            cfg_reg.zoom       <= '0;
            cfg_reg.mid_depth  <= '0;
            cfg_reg.near_depth <= RESET_NEAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODEL_YAW:
                begin
                    cfg_reg.model_cos <= cfg_data[TRIG_W-1:0];
                    cfg_reg.model_sin <= cfg_data[2*TRIG_W-1:TRIG_W];
                end
                REG_CAMERA_YAW:
                begin
                    cfg_reg.yaw_cos <= cfg_data[TRIG_W-1:0];
                    cfg_reg.yaw_sin <= cfg_data[2*TRIG_W-1:TRIG_W];
                end
                REG_CAMERA_PITCH:
                begin
                    cfg_reg.pitch_cos <= cfg_data[TRIG_W-1:0];
                    cfg_reg.pitch_sin <= cfg_data[2*TRIG_W-1:TRIG_W];
                end
                REG_OFFSET_X:   cfg_reg.offset_x <= cfg_data[DATA_W-1:0];
                REG_OFFSET_Y:   cfg_reg.offset_y <= cfg_data[DATA_W-1:0];
                REG_OFFSET_Z:   cfg_reg.offset_z <= cfg_data[DATA_W-1:0];
                REG_ZOOM:       cfg_reg.zoom     <= cfg_data[DATA_W-1:0];
                REG_DEPTH_PAIR:
                begin
                    cfg_reg.mid_depth  <= cfg_data[DATA_W-1:0];
                    cfg_reg.near_depth <= cfg_data[2*DATA_W-1:DATA_W];
                end
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/ovp_rotate.sv */
// Two-stage fixed-point rotation:
//   out_1 = ((a*c + b*s) >>> FRAC_BITS) + off_1
//   out_2 = ((b*c - a*s) >>> FRAC_BITS) + off_2
module ovp_rotate #(
    parameter int SIDE_W = 33
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  ovp_pkg::word_t      a,
    input  ovp_pkg::word_t      b,
    input  ovp_pkg::trig_t      cos_v,
    input  ovp_pkg::trig_t      sin_v,
    input  ovp_pkg::word_t      off_1,
    input  ovp_pkg::word_t      off_2,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_vld,
    output ovp_pkg::word_t      out_1,
    output ovp_pkg::word_t      out_2,
    output logic [SIDE_W-1:0]   side_out
);
    import ovp_pkg::*;

    word_t ac_full;
    word_t bs_full;
    word_t bc_full;
    word_t as_full;

    word_t ac_reg;
    word_t bs_reg;
    word_t bc_reg;
    word_t as_reg;
    logic  vld1_reg;
    logic [SIDE_W-1:0] side1_reg;

    word_t sum_1;
    word_t sum_2;
    word_t out_1_next;
    word_t out_2_next;
    word_t out_1_reg;
    word_t out_2_reg;
    logic  vld2_reg;
    logic [SIDE_W-1:0] side2_reg;

    // products: only the low word is kept, as everything wraps at 32 bits
    always_comb
    begin
        ac_full = a * word_t'(cos_v);
        bs_full = b * word_t'(sin_v);
        bc_full = b * word_t'(cos_v);
        as_full = a * word_t'(sin_v);
    end

    always_ff @(posedge clk)
    begin
        ac_reg    <= ac_full;
        bs_reg    <= bs_full;
        bc_reg    <= bc_full;
        as_reg    <= as_full;
        side1_reg <= side_in;
    end

    always_comb
    begin
        sum_1      = ac_reg + bs_reg;
        sum_2      = bc_reg - as_reg;
        out_1_next = (sum_1 >>> FRAC_BITS) + off_1;
        out_2_next = (sum_2 >>> FRAC_BITS) + off_2;
    end

    always_ff @(posedge clk)
    begin
        out_1_reg <= out_1_next;
        out_2_reg <= out_2_next;
        side2_reg <= side1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    assign out_vld  = vld2_reg;
    assign out_1    = out_1_reg;
    assign out_2    = out_2_reg;
    assign side_out = side2_reg;

endmodule

/* design/ovp_screen.sv */
// Zoom, near-plane clip and depth bias; results leave from registers.
module ovp_screen #(
    parameter int                 ZOOM_SHIFT = 16,
    parameter logic signed [31:0] CLIP_MARK  = 32'sh8000_0000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  ovp_pkg::word_t     cam_x_in,
    input  ovp_pkg::word_t     cam_y_in,
    input  ovp_pkg::word_t     cam_z_in,
    input  logic               batch_end_in,
    input  ovp_pkg::word_t     zoom,
    input  ovp_pkg::word_t     mid_depth,
    input  ovp_pkg::word_t     near_depth,
    output logic               out_vld,
    output ovp_pkg::word_t     cam_x,
    output ovp_pkg::word_t     cam_y,
    output ovp_pkg::word_t     cam_z,
    output ovp_pkg::word_t     scr_x,
    output ovp_pkg::word_t     scr_y,
    output ovp_pkg::word_t     scr_z,
    output logic               batch_end_out
);
    import ovp_pkg::*;

    word_t px_full;
    word_t py_full;

    word_t px_reg;
    word_t py_reg;
    logic  clip_reg;
    word_t cx1_reg;
    word_t cy1_reg;
    word_t cz1_reg;
    logic  be1_reg;
    logic  vld1_reg;

    word_t scr_x_next;
    word_t scr_y_next;
    word_t scr_z_next;
    word_t scr_x_reg;
    word_t scr_y_reg;
    word_t scr_z_reg;
    word_t cx2_reg;
    word_t cy2_reg;
    word_t cz2_reg;
    logic  be2_reg;
    logic  vld2_reg;

    always_comb
    begin
        px_full = cam_x_in * zoom;
        py_full = cam_y_in * zoom;
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_full;
        py_reg   <= py_full;
        clip_reg <= (cam_z_in < near_depth);
        cx1_reg  <= cam_x_in;
        cy1_reg  <= cam_y_in;
        cz1_reg  <= cam_z_in;
        be1_reg  <= batch_end_in;
    end

    always_comb
    begin
        scr_x_next = clip_reg ? CLIP_MARK : (px_reg >>> ZOOM_SHIFT);
        scr_y_next = py_reg >>> ZOOM_SHIFT;
        scr_z_next = cz1_reg - mid_depth;
    end

    always_ff @(posedge clk)
    begin
        scr_x_reg <= scr_x_next;
        scr_y_reg <= scr_y_next;
        scr_z_reg <= scr_z_next;
        cx2_reg   <= cx1_reg;
        cy2_reg   <= cy1_reg;
        cz2_reg   <= cz1_reg;
        be2_reg   <= be1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    assign out_vld       = vld2_reg;
    assign cam_x         = cx2_reg;
    assign cam_y         = cy2_reg;
    assign cam_z         = cz2_reg;
    assign scr_x         = scr_x_reg;
    assign scr_y         = scr_y_reg;
    assign scr_z         = scr_z_reg;
    assign batch_end_out = be2_reg;

endmodule

/* design/ortho_vertex_project.sv */
// Orthographic vertex transform. Each request carries one signed 16-bit
// model vertex (pos_x, pos_y, pos_z) and a batch_end flag; it is taken at
// any clock edge where start is high, and busy is always low, so a new
// vertex may enter every cycle. The results come out in request order,
// with done high for a single cycle with each result; the receiver cannot
// stall the block, so sample the result ports whenever done is high.
// The pipeline has three rotation units (model yaw, camera yaw, camera
// pitch), each a multiply stage followed by a sum/shift stage, then a
// zoom multiply stage and an output register stage. All arithmetic wraps
// at 32 bits and all shifts are arithmetic. Write the configuration
// registers only while no vertex is in flight: the pipeline reads them
// live in every stage.
module ortho_vertex_project #(
    parameter int                 ZOOM_SHIFT = 16,
    parameter logic signed [31:0] CLIP_MARK  = 32'sh8000_0000
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // vertex request
    input  logic                           start,
    output logic                           busy,
    input  logic signed [15:0]             pos_x,
    input  logic signed [15:0]             pos_y,
    input  logic signed [15:0]             pos_z,
    input  logic                           batch_end,
    // result
    output logic                           done,
    output logic signed [31:0]             cam_x,
    output logic signed [31:0]             cam_y,
    output logic signed [31:0]             cam_z,
    output logic signed [31:0]             scr_x,
    output logic signed [31:0]             scr_y,
    output logic signed [31:0]             scr_z,
    output logic                           batch_end_out,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [ovp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ovp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ovp_pkg::*;

    localparam int LATENCY = 3 * ROT_STAGES + SCR_STAGES;
    localparam int SIDE_W  = DATA_W + 1;

    cfg_t  cfg;
    logic  accept;

    word_t x_ext;
    word_t y_ext;
    word_t z_ext;
    word_t yr;

    // model yaw -> xr, zr
    logic              m_vld;
    word_t             m_xr;
    word_t             m_zr;
    logic [SIDE_W-1:0] m_side;

    // camera yaw -> cx, zc
    logic              c_vld;
    word_t             c_cx;
    word_t             c_zc;
    logic [SIDE_W-1:0] c_side;

    // camera pitch -> cz, cy
    logic              p_vld;
    word_t             p_cz;
    word_t             p_cy;
    logic [SIDE_W-1:0] p_side;

    // never hold off a request: one vertex enters per cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    ovp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sign-extend the vertex; y only takes the scene offset
    always_comb
    begin
        x_ext = {{(DATA_W-COORD_W){pos_x[COORD_W-1]}}, pos_x};
        y_ext = {{(DATA_W-COORD_W){pos_y[COORD_W-1]}}, pos_y};
        z_ext = {{(DATA_W-COORD_W){pos_z[COORD_W-1]}}, pos_z};
        yr    = y_ext + cfg.offset_y;
    end

    // model yaw plus scene translation
    ovp_rotate #(
        .SIDE_W (SIDE_W)
    ) u_model_yaw (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (accept),
        .a        (x_ext),
        .b        (z_ext),
        .cos_v    (cfg.model_cos),
        .sin_v    (cfg.model_sin),
        .off_1    (cfg.offset_x),
        .off_2    (cfg.offset_z),
        .side_in  ({yr, batch_end}),
        .out_vld  (m_vld),
        .out_1    (m_xr),
        .out_2    (m_zr),
        .side_out (m_side)
    );

    // camera yaw: carry yr along for the pitch step
    ovp_rotate #(
        .SIDE_W (SIDE_W)
    ) u_camera_yaw (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (m_vld),
        .a        (m_xr),
        .b        (m_zr),
        .cos_v    (cfg.yaw_cos),
        .sin_v    (cfg.yaw_sin),
        .off_1    ('0),
        .off_2    ('0),
        .side_in  (m_side),
        .out_vld  (c_vld),
        .out_1    (c_cx),
        .out_2    (c_zc),
        .side_out (c_side)
    );

    // camera pitch: a = zc, b = yr gives cz on the first output and cy on
    // the second; cx rides along as sideband
    ovp_rotate #(
        .SIDE_W (SIDE_W)
    ) u_camera_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (c_vld),
        .a        (c_zc),
        .b        (c_side[SIDE_W-1:1]),
        .cos_v    (cfg.pitch_cos),
        .sin_v    (cfg.pitch_sin),
        .off_1    ('0),
        .off_2    ('0),
        .side_in  ({c_cx, c_side[0]}),
        .out_vld  (p_vld),
        .out_1    (p_cz),
        .out_2    (p_cy),
        .side_out (p_side)
    );

    ovp_screen #(
        .ZOOM_SHIFT (ZOOM_SHIFT),
        .CLIP_MARK  (CLIP_MARK)
    ) u_screen (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_vld        (p_vld),
        .cam_x_in      (p_side[SIDE_W-1:1]),
        .cam_y_in      (p_cy),
        .cam_z_in      (p_cz),
        .batch_end_in  (p_side[0]),
        .zoom          (cfg.zoom),
        .mid_depth     (cfg.mid_depth),
        .near_depth    (cfg.near_depth),
        .out_vld       (done),
        .cam_x         (cam_x),
        .cam_y         (cam_y),
        .cam_z         (cam_z),
        .scr_x         (scr_x),
        .scr_y         (scr_y),
        .scr_z         (scr_z),
        .batch_end_out (batch_end_out)
    );

    // every request produces its result
    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("request did not produce a result on time");

    // no result without a request
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching request");

    // the batch flag stays with its vertex
    a_batch_end_kept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (batch_end_out == $past(batch_end, LATENCY)))
        else $error("batch_end_out separated from its vertex");

endmodule

/* tb/ortho_vertex_project_tb.sv */
`timescale 1ns / 1ps

module ortho_vertex_project_tb;

    import ovp_pkg::*;

    localparam int                 ZOOM_SHIFT  = 16;
    localparam logic signed [31:0] CLIP_MARK   = 32'sh8000_0000;
    // Give up after this many cycles in which no request, result or
    // register write moves. The longest quiet stretch of a correct run is
    // a sender gap or the pipeline drain.
    localparam int                 STALL_LIMIT = 400;
    localparam int                 PIPE_DEPTH  = 8;
    localparam int                 RAND_PHASES = 10;
    localparam int                 PHASE_ITEMS = 150;

    // Expected outputs for one vertex request.
    typedef struct {
        word_t cam_x;
        word_t cam_y;
        word_t cam_z;
        word_t scr_x;
        word_t scr_y;
        word_t scr_z;
        logic  batch_end;
    } projection_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic signed [15:0]    pos_x     = '0;
    logic signed [15:0]    pos_y     = '0;
    logic signed [15:0]    pos_z     = '0;
    logic                  batch_end = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  busy;
    logic                  done;
    logic signed [31:0]    cam_x;
    logic signed [31:0]    cam_y;
    logic signed [31:0]    cam_z;
    logic signed [31:0]    scr_x;
    logic signed [31:0]    scr_y;
    logic signed [31:0]    scr_z;
    logic                  batch_end_out;

    // Shadow of the configuration registers, updated on every write.
    cfg_t                  regs;
    // Projections still owed by the block, oldest first.
    projection_t           projected_queue[$];
    int                    mismatch_count = 0;
    int                    stall_cycles   = 0;

    ortho_vertex_project #(
        .ZOOM_SHIFT (ZOOM_SHIFT),
        .CLIP_MARK  (CLIP_MARK)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .batch_end     (batch_end),
        .done          (done),
        .cam_x         (cam_x),
        .cam_y         (cam_y),
        .cam_z         (cam_z),
        .scr_x         (scr_x),
        .scr_y         (scr_y),
        .scr_z         (scr_z),
        .batch_end_out (batch_end_out),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Run one vertex through the model yaw, the scene offset, the camera
    // yaw and the camera pitch, then zoom, clip and depth-bias it. Every
    // operand is a signed 32-bit word, so products and sums wrap at 32 bits
    // and >>> is arithmetic.
    function automatic projection_t project_vertex(input cfg_t c,
                                                   input logic signed [15:0] px,
                                                   input logic signed [15:0] py,
                                                   input logic signed [15:0] pz,
                                                   input logic be);
        word_t       x, y, z;
        word_t       cm, sm, cy, sy, cp, sp;
        word_t       xr, yr, zr, zc;
        projection_t r;
        x  = word_t'(px);
        y  = word_t'(py);
        z  = word_t'(pz);
        cm = word_t'(c.model_cos);
        sm = word_t'(c.model_sin);
        cy = word_t'(c.yaw_cos);
        sy = word_t'(c.yaw_sin);
        cp = word_t'(c.pitch_cos);
        sp = word_t'(c.pitch_sin);

        xr = ((x * cm + z * sm) >>> FRAC_BITS) + c.offset_x;
        zr = ((z * cm - x * sm) >>> FRAC_BITS) + c.offset_z;
        yr = y + c.offset_y;

        r.cam_x = (xr * cy + zr * sy) >>> FRAC_BITS;
        zc      = (zr * cy - xr * sy) >>> FRAC_BITS;
        r.cam_y = (yr * cp - zc * sp) >>> FRAC_BITS;
        r.cam_z = (yr * sp + zc * cp) >>> FRAC_BITS;

        r.scr_x = (r.cam_x * c.zoom) >>> (ZOOM_SHIFT % 32);
        r.scr_y = (r.cam_y * c.zoom) >>> (ZOOM_SHIFT % 32);
        // Depth below the near plane marks the vertex as clipped.
        if (r.cam_z < c.near_depth)
            r.scr_x = CLIP_MARK;
        r.scr_z     = r.cam_z - c.mid_depth;
        r.batch_end = be;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random value sources
    // ------------------------------------------------------------------

    function automatic logic [35:0] pack_trig(input trig_t cosv, input trig_t sinv);
        return {sinv, cosv};
    endfunction

    function automatic trig_t rnd_trig();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 5))
            0:       return 18'sh20000;
            1:       return 18'sh1FFFF;
            2:       return 18'sd0;
            3:       return RESET_COS;
            default: return trig_t'(raw[17:0]);
        endcase
    endfunction

    function automatic word_t rnd_word();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            3, 4:    return word_t'($urandom_range(0, 2000) - 1000);
            default: return word_t'(raw);
        endcase
    endfunction

    function automatic logic signed [15:0] rnd_coord();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sd0;
            default: return raw[15:0];
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Write one register. Hold the write for one edge, then drop the enable
    // and mirror the write into the shadow. Bits above a register's width
    // are ignored by the block, so ignore them here too.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_MODEL_YAW:
            begin
                regs.model_cos = data[17:0];
                regs.model_sin = data[35:18];
            end
            REG_CAMERA_YAW:
            begin
                regs.yaw_cos = data[17:0];
                regs.yaw_sin = data[35:18];
            end
            REG_CAMERA_PITCH:
            begin
                regs.pitch_cos = data[17:0];
                regs.pitch_sin = data[35:18];
            end
            REG_OFFSET_X:   regs.offset_x = data[31:0];
            REG_OFFSET_Y:   regs.offset_y = data[31:0];
            REG_OFFSET_Z:   regs.offset_z = data[31:0];
            REG_ZOOM:       regs.zoom     = data[31:0];
            REG_DEPTH_PAIR:
            begin
                regs.mid_depth  = data[31:0];
                regs.near_depth = data[63:32];
            end
            default: ;
        endcase
    endtask

    // Program every register. Fill the unused upper bits with noise so that
    // the block is seen to drop them.
    task automatic program_registers(input logic [35:0] model_yaw,
                                     input logic [35:0] camera_yaw,
                                     input logic [35:0] camera_pitch,
                                     input word_t ox, input word_t oy, input word_t oz,
                                     input word_t zoom, input logic [63:0] depth);
        logic [63:0] noise;
        noise = {$urandom(), $urandom()};
        write_reg(REG_MODEL_YAW,    {noise[63:36], model_yaw});
        write_reg(REG_CAMERA_YAW,   {noise[35:8], camera_yaw});
        write_reg(REG_CAMERA_PITCH, {noise[27:0], camera_pitch});
        write_reg(REG_OFFSET_X,     {noise[63:32], ox});
        write_reg(REG_OFFSET_Y,     {noise[31:0], oy});
        write_reg(REG_OFFSET_Z,     {noise[47:16], oz});
        write_reg(REG_ZOOM,         {noise[55:24], zoom});
        write_reg(REG_DEPTH_PAIR,   depth);
    endtask

    // Send one vertex request. Raise start with the fields, wait for the
    // edge that takes it, record the projection it owes, then idle for
    // the given gap. Start stays high when the gap is zero, so back-to-back
    // requests never see start dropped and raised in one step.
    task automatic send_vertex(input logic signed [15:0] px,
                               input logic signed [15:0] py,
                               input logic signed [15:0] pz,
                               input logic be, input int gap);
        start     <= 1'b1;
        pos_x     <= px;
        pos_y     <= py;
        pos_z     <= pz;
        batch_end <= be;
        do
            @(posedge clk);
        while (busy);
        projected_queue.push_back(project_vertex(regs, px, py, pz, be));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every owed result. Every request yields a
    // result, so an empty queue means an empty pipeline.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (projected_queue.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves identity rotations, zero offsets, zero zoom and the
    // unclipped near plane, so the camera outputs equal the input vertex.
    task automatic test_reset_defaults();
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 0);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 0);
        send_vertex(16'sd0, 16'sd0, 16'sd0, 1'b0, 3);
        send_vertex(-16'sd1, 16'sd1, -16'sd1, 1'b1, 1);
        drain_pipeline();
    endtask

    // With identity rotations the final depth is pos_z plus offset_z, so
    // step the depth across the near plane: one below clips, equal does not.
    task automatic test_clip_boundary();
        program_registers(pack_trig(RESET_COS, RESET_SIN), pack_trig(RESET_COS, RESET_SIN),
                          pack_trig(RESET_COS, RESET_SIN), 32'sd0, 32'sd0, 32'sd0,
                          32'sd65536, {32'sd100, -32'sd5});
        send_vertex(16'sd7, -16'sd3, 16'sd99, 1'b0, 0);
        send_vertex(16'sd7, -16'sd3, 16'sd100, 1'b0, 0);
        send_vertex(16'sd7, -16'sd3, 16'sd101, 1'b1, 2);
        drain_pipeline();
    endtask

    // Push every register and field to its extremes so that each product,
    // sum and shift wraps.
    task automatic test_wraparound_extremes();
        program_registers(pack_trig(18'sh1FFFF, 18'sh20000), pack_trig(18'sh20000, 18'sh1FFFF),
                          pack_trig(18'sh1FFFF, 18'sh1FFFF), 32'sh7FFF_FFFF, 32'sh8000_0000,
                          32'sh7FFF_FFFF, 32'sh8000_0000, {RESET_NEAR, 32'sh7FFF_FFFF});
        send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 0);
        send_vertex(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1, 0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 0);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1);
        drain_pipeline();

        // Near plane at the top: everything clips except a depth at maximum.
        program_registers(pack_trig(18'sh20000, 18'sh20000), pack_trig(18'sh1FFFF, 18'sh20000),
                          pack_trig(18'sh20000, 18'sh1FFFF), 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh7FFF_FFFF, {32'sh7FFF_FFFF, 32'sh8000_0000});
        send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 0);
        send_vertex(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, 0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1, 0);
        send_vertex(16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, 2);
        drain_pipeline();
    endtask

    // Random settings, each followed by a stream of random vertices sent in
    // bursts. Some phases run at full rate with no gaps at all.
    task automatic test_random_phases();
        int          burst_left;
        int          gap;
        bit          full_rate;
        logic [31:0] near_plane;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            near_plane = ($urandom_range(0, 2) == 0) ? RESET_NEAR : rnd_word();
            program_registers(pack_trig(rnd_trig(), rnd_trig()),
                              pack_trig(rnd_trig(), rnd_trig()),
                              pack_trig(rnd_trig(), rnd_trig()),
                              rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                              {near_plane, rnd_word()});
            full_rate  = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                burst_left--;
                gap = 0;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    if (!full_rate)
                        gap = $urandom_range(1, 12);
                end
                send_vertex(rnd_coord(), rnd_coord(), rnd_coord(), 1'($urandom()), gap);
            end
            drain_pipeline();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string field, input word_t want, input word_t got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Take each result at the edge that ends its done cycle and hold it
    // against the oldest owed projection.
    always @(posedge clk)
    begin
        projection_t want;
        if (rst_n && done)
        begin
            if (projected_queue.size() == 0)
            begin
                $error("result with no request outstanding: cam_x %0d", cam_x);
                mismatch_count++;
            end
            else
            begin
                want = projected_queue.pop_front();
                check_field("cam_x", want.cam_x, cam_x);
                check_field("cam_y", want.cam_y, cam_y);
                check_field("cam_z", want.cam_z, cam_z);
                check_field("scr_x", want.scr_x, scr_x);
                check_field("scr_y", want.scr_y, scr_y);
                check_field("scr_z", want.scr_z, scr_z);
                check_field("batch_end_out", word_t'(want.batch_end),
                            word_t'(batch_end_out));
            end
        end
    end

    // Count cycles in which nothing moves; a hung block ends the run here.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        regs = '{model_cos: RESET_COS, model_sin: RESET_SIN,
                 yaw_cos: RESET_COS, yaw_sin: RESET_SIN,
                 pitch_cos: RESET_COS, pitch_sin: RESET_SIN,
                 offset_x: '0, offset_y: '0, offset_z: '0, zoom: '0,
                 mid_depth: '0, near_depth: RESET_NEAR};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_clip_boundary();
        test_wraparound_extremes();
        test_random_phases();

        // Idle after the last test so that a stray result is caught.
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
